// ----- rtl/tftp_packet_parser_macros.svh -----
// Assertion macros for the TFTP packet parser.
// Used by tftp_packet_parser.sv; expects clk and arst_n in scope.
`ifndef TFTP_PACKET_PARSER_MACROS_SVH
`define TFTP_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tpp_pkg.sv -----
// Types and codes for the TFTP packet parser.
// No dependencies; imported by tftp_packet_parser.
`default_nettype none

package tpp_pkg;

	// field_kind codes
	localparam logic [2:0] KIND_OPCODE  = 3'd0;
	localparam logic [2:0] KIND_NUMBER  = 3'd1;
	localparam logic [2:0] KIND_NAME    = 3'd2;
	localparam logic [2:0] KIND_MODE    = 3'd3;
	localparam logic [2:0] KIND_DATA    = 3'd4;
	localparam logic [2:0] KIND_MESSAGE = 3'd5;
	localparam logic [2:0] KIND_TERM    = 3'd6;
	localparam logic [2:0] KIND_DISCARD = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_OP  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_EARLY   = 2'd3;

	// opcodes
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_RRQ   = 3'd1;
	localparam logic [2:0] OP_WRQ   = 3'd2;
	localparam logic [2:0] OP_DATA  = 3'd3;
	localparam logic [2:0] OP_ACK   = 3'd4;
	localparam logic [2:0] OP_ERROR = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_NAME_LIMIT    = 2'd0;
	localparam logic [1:0] REG_MODE_LIMIT    = 2'd1;
	localparam logic [1:0] REG_MESSAGE_LIMIT = 2'd2;

	localparam logic [7:0] NAME_LIMIT_RST    = 8'd23;
	localparam logic [7:0] MODE_LIMIT_RST    = 8'd7;
	localparam logic [7:0] MESSAGE_LIMIT_RST = 8'd63;

	localparam logic [8:0] OFFSET_MAX = 9'd511;

	typedef enum logic [9:0] {
		PH_OP0   = 10'b00_0000_0001,
		PH_OP1   = 10'b00_0000_0010,
		PH_NUM0  = 10'b00_0000_0100,
		PH_NUM1  = 10'b00_0000_1000,
		PH_NAME  = 10'b00_0001_0000,
		PH_MODE  = 10'b00_0010_0000,
		PH_DATA  = 10'b00_0100_0000,
		PH_MSG   = 10'b00_1000_0000,
		PH_AFTER = 10'b01_0000_0000,
		PH_BAD   = 10'b10_0000_0000
	} phase_t;

endpackage

`default_nettype wire

// ----- rtl/tftp_packet_parser.sv -----
// TFTP (RFC 1350) packet parser, byte-wide, one result per byte.
// Depends on tpp_pkg and tftp_packet_parser_macros.svh.
`default_nettype none
`include "tftp_packet_parser_macros.svh"

// Takes a TFTP packet one byte per request, end_of_packet set on the last
// byte, and returns one result request per byte: the byte's field kind,
// its offset in the field (saturating at 511), the opcode and 16-bit
// block number / error code decoded so far (big-endian), and a sticky
// per-packet status (bad opcode, field too long, ended early; first fault
// wins). Throughput is one byte per cycle while out_stall is low: an
// input register feeds a single pass of parse logic that updates the
// packet state and loads the result register, where out_valid flags the
// result. The input register keeps taking bytes while a result waits, as
// long as it has been drained into the result register. The user must
// write limits on the wr_* port only while the block is idle; the block
// itself does not enforce it. All per-packet state returns to reset after
// the last byte of a packet. DATA_LIMIT sets the payload size above which
// DATA bytes are discarded and flagged.
module tftp_packet_parser
	import tpp_pkg::*;
#(
	parameter int DATA_LIMIT = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [7:0]  wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        end_of_packet,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       field_kind,
	output logic [7:0]       byte_value,
	output logic [8:0]       field_offset,
	output logic [2:0]       packet_opcode,
	output logic [15:0]      packet_number,
	output logic             packet_done,
	output logic [1:0]       status
);

	// Field counter must reach DATA_LIMIT and also 511 for the offset.
	localparam int CNT_W = ($clog2(DATA_LIMIT + 1) > 10) ? $clog2(DATA_LIMIT + 1) : 10;
	localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] DATA_LIM = CNT_W'(DATA_LIMIT);

	// config registers
	logic [7:0] name_limit_q, mode_limit_q, message_limit_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eop_s1;

	// packet state
	phase_t           phase_q;
	logic [2:0]       opcode_q;
	logic [7:0]       op_high_q;
	logic [7:0]       num_high_q;
	logic [7:0]       num_low_q;
	logic             num_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       fault_q;

	// next-state and result
	phase_t           phase_d;
	logic [2:0]       opcode_d;
	logic [7:0]       op_high_d;
	logic [7:0]       num_high_d;
	logic [7:0]       num_low_d;
	logic             num_valid_d;
	logic [CNT_W-1:0] count_d;
	logic [1:0]       fault_d;
	logic [2:0]       kind_c;
	logic [CNT_W-1:0] off_c;
	logic [CNT_W-1:0] count_inc;
	logic [7:0]       str_limit;
	logic [2:0]       str_kind;
	phase_t           str_next;

	logic advance, fire, accept;

	// The result register can load when empty or being drained.
	assign advance  = !out_valid || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_limit_q    <= NAME_LIMIT_RST;
			mode_limit_q    <= MODE_LIMIT_RST;
			message_limit_q <= MESSAGE_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_NAME_LIMIT:    name_limit_q    <= wr_data;
				REG_MODE_LIMIT:    mode_limit_q    <= wr_data;
				REG_MESSAGE_LIMIT: message_limit_q <= wr_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
			eop_s1  <= end_of_packet;
		end
	end

	assign count_inc = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);

	// string field selection per phase
	always_comb begin
		case (phase_q)
			PH_NAME: begin
				str_limit = name_limit_q;
				str_kind  = KIND_NAME;
				str_next  = PH_MODE;
			end
			PH_MODE: begin
				str_limit = mode_limit_q;
				str_kind  = KIND_MODE;
				str_next  = PH_AFTER;
			end
			default: begin
				str_limit = message_limit_q;
				str_kind  = KIND_MESSAGE;
				str_next  = PH_AFTER;
			end
		endcase
	end

	// parse one byte against the packet state
	always_comb begin
		phase_d     = phase_q;
		opcode_d    = opcode_q;
		op_high_d   = op_high_q;
		num_high_d  = num_high_q;
		num_low_d   = num_low_q;
		num_valid_d = num_valid_q;
		count_d     = count_q;
		fault_d     = fault_q;
		kind_c      = KIND_DISCARD;
		off_c       = '0;
		case (phase_q)
			PH_OP0: begin
				kind_c    = KIND_OPCODE;
				op_high_d = byte_s1;
				phase_d   = PH_OP1;
			end
			PH_OP1: begin
				kind_c = KIND_OPCODE;
				off_c  = CNT_W'(1);
				if (op_high_q == 8'd0 && byte_s1 inside {[8'd1:8'd5]}) begin
					opcode_d = byte_s1[2:0];
					phase_d  = (byte_s1 <= 8'd2) ? PH_NAME : PH_NUM0;
					count_d  = '0;
				end else begin
					opcode_d = OP_NONE;
					if (fault_q == ST_OK) fault_d = ST_BAD_OP;
					phase_d = PH_BAD;
				end
			end
			PH_NUM0: begin
				kind_c     = KIND_NUMBER;
				num_high_d = byte_s1;
				phase_d    = PH_NUM1;
			end
			PH_NUM1: begin
				kind_c      = KIND_NUMBER;
				off_c       = CNT_W'(1);
				num_low_d   = byte_s1;
				num_valid_d = 1'b1;
				count_d     = '0;
				if (opcode_q == OP_DATA)     phase_d = PH_DATA;
				else if (opcode_q == OP_ACK) phase_d = PH_AFTER;
				else                         phase_d = PH_MSG;
			end
			PH_NAME, PH_MODE, PH_MSG: begin
				off_c = count_q;
				if (byte_s1 == 8'd0) begin
					kind_c  = KIND_TERM;
					phase_d = str_next;
					count_d = '0;
				end else begin
					count_d = count_inc;
					if (count_q < CNT_W'(str_limit)) begin
						kind_c = str_kind;
					end else begin
						kind_c = KIND_DISCARD;
						if (fault_q == ST_OK) fault_d = ST_TOO_LONG;
					end
				end
			end
			PH_DATA: begin
				off_c   = count_q;
				count_d = count_inc;
				if (count_q < DATA_LIM) begin
					kind_c = KIND_DATA;
				end else begin
					kind_c = KIND_DISCARD;
					if (fault_q == ST_OK) fault_d = ST_TOO_LONG;
				end
			end
			default: ; // after a complete packet or a bad opcode: discard
		endcase
		// packet cut short: only DATA, a finished packet or a bad one may end here
		if (eop_s1 && fault_d == ST_OK && phase_d != PH_DATA && phase_d != PH_AFTER
				&& phase_d != PH_BAD) begin
			fault_d = ST_EARLY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OP0;
			opcode_q    <= OP_NONE;
			op_high_q   <= '0;
			num_high_q  <= '0;
			num_low_q   <= '0;
			num_valid_q <= 1'b0;
			count_q     <= '0;
			fault_q     <= ST_OK;
		end else if (fire) begin
			if (eop_s1) begin
				phase_q     <= PH_OP0;
				opcode_q    <= OP_NONE;
				op_high_q   <= '0;
				num_high_q  <= '0;
				num_low_q   <= '0;
				num_valid_q <= 1'b0;
				count_q     <= '0;
				fault_q     <= ST_OK;
			end else begin
				phase_q     <= phase_d;
				opcode_q    <= opcode_d;
				op_high_q   <= op_high_d;
				num_high_q  <= num_high_d;
				num_low_q   <= num_low_d;
				num_valid_q <= num_valid_d;
				count_q     <= count_d;
				fault_q     <= fault_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			field_kind    <= kind_c;
			byte_value    <= byte_s1;
			field_offset  <= (off_c > CNT_W'(OFFSET_MAX)) ? OFFSET_MAX : off_c[8:0];
			packet_opcode <= opcode_d;
			packet_number <= num_valid_d ? {num_high_d, num_low_d} : 16'd0;
			packet_done   <= eop_s1;
			status        <= fault_d;
		end
	end

	// A held result must block the input register from being overwritten.
	`TPP_ASSERT_IMP(a_hold_blocks_input, valid_s1 && out_valid && out_stall, in_stall, "input register not held behind a stalled result")
	// The last byte of a packet leaves the parser ready for a new opcode.
	`TPP_ASSERT_NEXT(a_eop_clears, fire && eop_s1, phase_q == PH_OP0 && fault_q == ST_OK && !num_valid_q, "packet state not cleared after last byte")
	// Within a packet the first fault stays.
	`TPP_ASSERT_NEXT(a_fault_sticky, fire && !eop_s1 && fault_q != ST_OK, fault_q == $past(fault_q), "packet fault changed before end of packet")
	// Payload bytes only appear in a DATA packet.
	`TPP_ASSERT_IMP(a_data_kind, out_valid && field_kind == KIND_DATA, packet_opcode == OP_DATA, "data byte reported outside a DATA packet")

endmodule

`default_nettype wire

// ----- bench/tb_tftp_packet_parser.sv -----
// Self-checking bench for tftp_packet_parser: directed and random TFTP packets.
// Depends on tpp_pkg and the RTL; a scoreboard class predicts every result request.
import tpp_pkg::*;

typedef logic [7:0] byte_q_t[$];

typedef struct packed {
	logic [2:0]  kind;
	logic [7:0]  value;
	logic [8:0]  offset;
	logic [2:0]  opcode;
	logic [15:0] number;
	logic        done;
	logic [1:0]  status;
} parse_result_t;

class parse_scoreboard;
	localparam int unsigned COUNT_MAX = 2047;
	localparam int unsigned PAYLOAD_LIMIT = 512;

	logic [7:0]    name_limit, mode_limit, message_limit;
	phase_t        phase;
	logic [2:0]    opcode;
	logic [7:0]    op_high, num_high, num_low;
	bit            num_valid;
	int unsigned   count;
	logic [1:0]    fault;
	parse_result_t pending_results[$];
	int unsigned   mismatches;

	function new();
		name_limit = NAME_LIMIT_RST;
		mode_limit = MODE_LIMIT_RST;
		message_limit = MESSAGE_LIMIT_RST;
		mismatches = 0;
		clear_packet();
	endfunction

	function void clear_packet();
		phase = PH_OP0;
		opcode = OP_NONE;
		op_high = 8'd0;
		num_high = 8'd0;
		num_low = 8'd0;
		num_valid = 1'b0;
		count = 0;
		fault = ST_OK;
	endfunction

	function void set_limit(logic [1:0] idx, logic [7:0] v);
		case (idx)
			REG_NAME_LIMIT:    name_limit = v;
			REG_MODE_LIMIT:    mode_limit = v;
			REG_MESSAGE_LIMIT: message_limit = v;
			default: ;
		endcase
	endfunction

	// first fault in a packet is sticky
	function void latch_fault(logic [1:0] code);
		if (fault == ST_OK)
			fault = code;
	endfunction

	function void bump_count();
		if (count < COUNT_MAX)
			count++;
	endfunction

	// NUL ends the string; characters at or past the limit are dropped
	function logic [2:0] string_char(logic [7:0] b, logic [7:0] lim, logic [2:0] kind,
			phase_t next_phase, output int unsigned off);
		off = count;
		if (b == 8'd0) begin
			phase = next_phase;
			count = 0;
			return KIND_TERM;
		end
		bump_count();
		if (off < lim)
			return kind;
		latch_fault(ST_TOO_LONG);
		return KIND_DISCARD;
	endfunction

	function parse_result_t classify_byte(logic [7:0] b, logic eop);
		parse_result_t r;
		int unsigned off;
		r.kind = KIND_DISCARD;
		off = 0;
		case (phase)
			PH_OP0: begin
				r.kind = KIND_OPCODE;
				op_high = b;
				phase = PH_OP1;
			end
			PH_OP1: begin
				r.kind = KIND_OPCODE;
				off = 1;
				if (op_high == 8'd0 && b >= 8'd1 && b <= 8'd5) begin
					opcode = b[2:0];
					phase = (b[2:0] <= OP_WRQ) ? PH_NAME : PH_NUM0;
					count = 0;
				end else begin
					opcode = OP_NONE;
					latch_fault(ST_BAD_OP);
					phase = PH_BAD;
				end
			end
			PH_NUM0: begin
				r.kind = KIND_NUMBER;
				num_high = b;
				phase = PH_NUM1;
			end
			PH_NUM1: begin
				r.kind = KIND_NUMBER;
				off = 1;
				num_low = b;
				num_valid = 1'b1;
				count = 0;
				if (opcode == OP_DATA)
					phase = PH_DATA;
				else if (opcode == OP_ACK)
					phase = PH_AFTER;
				else
					phase = PH_MSG;
			end
			PH_NAME: r.kind = string_char(b, name_limit, KIND_NAME, PH_MODE, off);
			PH_MODE: r.kind = string_char(b, mode_limit, KIND_MODE, PH_AFTER, off);
			PH_MSG:  r.kind = string_char(b, message_limit, KIND_MESSAGE, PH_AFTER, off);
			PH_DATA: begin
				off = count;
				bump_count();
				if (off < PAYLOAD_LIMIT) begin
					r.kind = KIND_DATA;
				end else begin
					latch_fault(ST_TOO_LONG);
				end
			end
			default: ;
		endcase
		if (eop && phase != PH_DATA && phase != PH_AFTER && phase != PH_BAD)
			latch_fault(ST_EARLY);
		if (off > OFFSET_MAX)
			off = OFFSET_MAX;
		r.value = b;
		r.offset = off[8:0];
		r.opcode = opcode;
		r.number = num_valid ? {num_high, num_low} : 16'd0;
		r.done = eop;
		r.status = fault;
		if (eop)
			clear_packet();
		return r;
	endfunction

	function void note_request(logic [7:0] b, logic eop);
		pending_results.push_back(classify_byte(b, eop));
	endfunction

	function void check_result(parse_result_t seen);
		parse_result_t want;
		if (pending_results.size() == 0) begin
			$error("result with no request pending: byte_value %0d", seen.value);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		if (seen.kind !== want.kind) begin
			$error("field_kind: expected %0d, got %0d", want.kind, seen.kind);
			mismatches++;
		end
		if (seen.value !== want.value) begin
			$error("byte_value: expected %0d, got %0d", want.value, seen.value);
			mismatches++;
		end
		if (seen.offset !== want.offset) begin
			$error("field_offset: expected %0d, got %0d", want.offset, seen.offset);
			mismatches++;
		end
		if (seen.opcode !== want.opcode) begin
			$error("packet_opcode: expected %0d, got %0d", want.opcode, seen.opcode);
			mismatches++;
		end
		if (seen.number !== want.number) begin
			$error("packet_number: expected %0d, got %0d", want.number, seen.number);
			mismatches++;
		end
		if (seen.done !== want.done) begin
			$error("packet_done: expected %0d, got %0d", want.done, seen.done);
			mismatches++;
		end
		if (seen.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, seen.status);
			mismatches++;
		end
	endfunction
endclass

module tb_tftp_packet_parser;
	import tpp_pkg::*;

	localparam int DATA_LIMIT = 512;
	localparam int PHASE_BYTES = 60;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_ALTERNATE,
		STALL_HEAVY
	} stall_mode_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = REG_NAME_LIMIT;
	logic [7:0]  wr_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        end_of_packet = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  field_kind;
	logic [7:0]  byte_value;
	logic [8:0]  field_offset;
	logic [2:0]  packet_opcode;
	logic [15:0] packet_number;
	logic        packet_done;
	logic [1:0]  status;

	parse_scoreboard sb;
	byte_q_t         pkt;
	int unsigned     burst_left = 0;
	stall_mode_t     stall_mode = STALL_NONE;
	logic [7:0]      stall_cycle = 8'd0;

	tftp_packet_parser #(
		.DATA_LIMIT(DATA_LIMIT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.end_of_packet(end_of_packet),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.field_kind   (field_kind),
		.byte_value   (byte_value),
		.field_offset (field_offset),
		.packet_opcode(packet_opcode),
		.packet_number(packet_number),
		.packet_done  (packet_done),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Result side: the stall pattern periodically picks a random mode, so we see
	// free-running stretches, random back-pressure, strict alternation, and
	// long stall runs that fill up the block's internal registers.
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 8'd1;
		if (stall_cycle[5:0] == 6'd0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:      out_stall <= 1'b0;
			STALL_RANDOM:    out_stall <= ($urandom_range(0, 2) == 0);
			STALL_ALTERNATE: out_stall <= stall_cycle[0];
			default:         out_stall <= (stall_cycle[3:0] < 4'd11);
		endcase
	end

	// Every accepted result request is checked against the oldest prediction.
	// Outputs are read just after the edge, i.e. the values the edge sampled.
	always @(posedge clk) begin : watch_results
		parse_result_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.kind = field_kind;
			seen.value = byte_value;
			seen.offset = field_offset;
			seen.opcode = packet_opcode;
			seen.number = packet_number;
			seen.done = packet_done;
			seen.status = status;
			sb.check_result(seen);
		end
	end

	// Sender works in bursts; between bursts valid drops for a random gap.
	// A gap of zero keeps valid high, so some bursts run back to back.
	task automatic send_byte(logic [7:0] b, logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte <= b;
		end_of_packet <= last;
		do @(posedge clk); while (in_stall);
		sb.note_request(b, last);
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	// Drop valid and let every outstanding result drain, plus a margin for
	// the two-stage pipe, so the limits change only while the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limits(logic [7:0] name_lim, logic [7:0] mode_lim,
			logic [7:0] msg_lim);
		logic [7:0] vals[3];
		vals[REG_NAME_LIMIT] = name_lim;
		vals[REG_MODE_LIMIT] = mode_lim;
		vals[REG_MESSAGE_LIMIT] = msg_lim;
		for (int i = 0; i < 3; i++) begin
			wr_en <= 1'b1;
			wr_index <= i[1:0];
			wr_data <= vals[i];
			@(posedge clk);
			sb.set_limit(i[1:0], vals[i]);
		end
		wr_en <= 1'b0;
	endtask

	// Mostly random bytes with a bias toward 0x00 and 0xFF.
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// NUL-terminated string; lengths cluster around the limit when it is
	// small enough to reach, so over-long fields show up often.
	task automatic append_string(logic [7:0] lim);
		int unsigned len;
		if (lim <= 8'd30 && $urandom_range(0, 2) == 0)
			len = $urandom_range((lim == 8'd0) ? 0 : lim - 1, lim + 2);
		else
			len = $urandom_range(0, (lim < 8'd12) ? lim : 12);
		repeat (len)
			pkt.push_back(8'($urandom_range(1, 255)));
		pkt.push_back(8'h00);
	endtask

	task automatic build_packet(bit long_payload);
		int unsigned pick, n;
		logic [2:0]  op;
		logic [7:0]  hi;
		pkt = {};
		pick = $urandom_range(0, 99);
		if (long_payload)
			pick = 60;
		if (pick < 8) begin
			// line noise
			n = $urandom_range(1, 12);
			repeat (n)
				pkt.push_back(pick_byte());
		end else if (pick < 14) begin
			// bad opcode, sometimes with bytes trailing it
			hi = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
			pkt.push_back(hi);
			if (hi == 8'h00)
				pkt.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(6, 255)));
			else
				pkt.push_back(pick_byte());
			n = $urandom_range(0, 4);
			repeat (n)
				pkt.push_back(pick_byte());
		end else begin
			if (pick < 34)
				op = OP_RRQ;
			else if (pick < 48)
				op = OP_WRQ;
			else if (pick < 72)
				op = OP_DATA;
			else if (pick < 84)
				op = OP_ACK;
			else
				op = OP_ERROR;
			pkt.push_back(8'h00);
			pkt.push_back({5'd0, op});
			case (op)
				OP_RRQ, OP_WRQ: begin
					append_string(sb.name_limit);
					append_string(sb.mode_limit);
				end
				OP_DATA: begin
					pkt.push_back(pick_byte());
					pkt.push_back(pick_byte());
					n = long_payload ? $urandom_range(DATA_LIMIT - 4, DATA_LIMIT + 12)
						: $urandom_range(0, 16);
					repeat (n)
						pkt.push_back(pick_byte());
				end
				OP_ACK: begin
					pkt.push_back(pick_byte());
					pkt.push_back(pick_byte());
				end
				default: begin
					pkt.push_back(pick_byte());
					pkt.push_back(pick_byte());
					append_string(sb.message_limit);
				end
			endcase
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 4);
				repeat (n)
					pkt.push_back(pick_byte());
			end
		end
		// cut some packets short to hit the early-end path in every field
		if (!long_payload && pkt.size() > 1 && $urandom_range(0, 7) == 0)
			pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
	endtask

	task automatic random_packets(int unsigned budget, bit with_long);
		int unsigned sent;
		sent = 0;
		if (with_long) begin
			build_packet(1'b1);
			send_packet();
		end
		while (sent < budget) begin
			build_packet(1'b0);
			send_packet();
			sent += pkt.size();
		end
	endtask

	task automatic run_phase(logic [7:0] name_lim, logic [7:0] mode_lim,
			logic [7:0] msg_lim, bit with_long);
		drain();
		write_limits(name_lim, mode_lim, msg_lim);
		random_packets(PHASE_BYTES, with_long);
	endtask

	initial begin
		int unsigned waited;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed packets under the reset limits.
		// opcode 0 is rejected
		pkt = '{8'h00, 8'h00};
		send_packet();
		// nonzero high opcode byte, then a byte after the bad opcode
		pkt = '{8'hFF, 8'h01, 8'h80};
		send_packet();
		// ACK with one trailing byte
		pkt = '{8'h00, 8'h04, 8'h12, 8'h34, 8'hFF};
		send_packet();
		// DATA with an empty payload is complete
		pkt = '{8'h00, 8'h03, 8'hFF, 8'hFF};
		send_packet();
		// ERROR with a one-character message
		pkt = '{8'h00, 8'h05, 8'h00, 8'h01, 8'h41, 8'h00};
		send_packet();
		// RRQ with one-character name and mode
		pkt = '{8'h00, 8'h01, 8'h61, 8'h00, 8'h62, 8'h00};
		send_packet();
		// WRQ that stops inside the filename
		pkt = '{8'h00, 8'h02, 8'h66};
		send_packet();

		random_packets(PHASE_BYTES, 1'b0);

		// Limit extremes, zero limits included, then a few small settings.
		run_phase(8'd0, 8'd255, 8'd1, 1'b1);
		run_phase(8'd255, 8'd0, 8'd255, 1'b0);
		run_phase(8'd1, 8'd1, 8'd0, 1'b0);
		run_phase(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
			8'($urandom_range(1, 12)), 1'b0);
		run_phase(8'd5, 8'd3, 8'd20, 1'b0);

		in_valid <= 1'b0;
		waited = 0;
		while (sb.pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending_results.size() != 0)
			$error("%0d results never arrived", sb.pending_results.size());
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tpp_pkg.sv
rtl/tftp_packet_parser.sv
bench/tb_tftp_packet_parser.sv
